// ===== design/c_like_token_lexer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// c_like_token_lexer_unit_assert
// assertion macros used by the lexer rtl
// ----------------------------------------------------------------------------
`ifndef C_LIKE_TOKEN_LEXER_UNIT_ASSERT_SVH
`define C_LIKE_TOKEN_LEXER_UNIT_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define CLT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CLT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// types, constants and token lookup functions of the c-like token lexer
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

   // width of the bracket depth counter
   localparam int DEPTH_BITS = 8;
   localparam int LEVEL_CALC_BITS = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

   // results per input word and depth of the result queue
   localparam int MAX_RESULTS = 3;
   localparam int RSP_SLOTS   = 2 * MAX_RESULTS;
   localparam int COUNT_BITS  = $clog2(RSP_SLOTS + 1);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_OPER,
      MODE_LINE,
      MODE_BLOCK,
      MODE_STAR
   } mode_type;

   typedef enum logic [1:0] {
      KIND_PUNCT,
      KIND_IDENT,
      KIND_OPER,
      KIND_END
   } token_kind_type;

   typedef enum logic [5:0] {
      OP_SHL_ASN, OP_SHR_ASN, OP_SPACESHIP,
      OP_INC, OP_DEC, OP_SHL, OP_SHR, OP_ADD_ASN, OP_SUB_ASN,
      OP_MUL_ASN, OP_DIV_ASN, OP_MOD_ASN, OP_OR_ASN, OP_XOR_ASN, OP_LE,
      OP_GE, OP_NE, OP_EQ, OP_LAND, OP_LOR, OP_ARROW,
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND,
      OP_NOT, OP_XOR, OP_ASN, OP_LNOT, OP_LT, OP_GT
   } op_code_type;

   typedef struct packed {
      logic        hit;
      op_code_type code;
   } op_hit_type;

   typedef struct packed {
      token_kind_type     kind;
      logic [7:0]         char_value;
      logic [5:0]         operator_code;
      logic signed [7:0]  nesting_level;
      logic               ident_last;
      logic               group_end;
   } result_type;

   typedef struct packed {
      mode_type                     mode;
      logic [7:0]                   held0;
      logic [7:0]                   held1;
      logic [1:0]                   held_count;
      logic signed [DEPTH_BITS-1:0] depth;
   } lex_state_type;

   typedef struct packed {
      lex_state_type   st;
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]      cnt;
   } step_type;

   localparam lex_state_type LEX_RESET = '{
      mode: MODE_IDLE, held0: 8'h00, held1: 8'h00, held_count: 2'd0, depth: '0};

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic op_hit_type find3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      op_hit_type h;
      h = '{hit: 1'b1, code: OP_SHL_ASN};
      case ({a, b, c})
         "<<=":   h.code = OP_SHL_ASN;
         ">>=":   h.code = OP_SHR_ASN;
         "<=>":   h.code = OP_SPACESHIP;
         default: h.hit  = 1'b0;
      endcase
      return h;
   endfunction

   function automatic logic prefix3(input logic [7:0] a, input logic [7:0] b);
      return ({a, b} == "<<") || ({a, b} == ">>") || ({a, b} == "<=");
   endfunction

   function automatic op_hit_type find2(input logic [7:0] a, input logic [7:0] b);
      op_hit_type h;
      h = '{hit: 1'b1, code: OP_INC};
      case ({a, b})
         "++":    h.code = OP_INC;
         "--":    h.code = OP_DEC;
         "<<":    h.code = OP_SHL;
         ">>":    h.code = OP_SHR;
         "+=":    h.code = OP_ADD_ASN;
         "-=":    h.code = OP_SUB_ASN;
         "*=":    h.code = OP_MUL_ASN;
         "/=":    h.code = OP_DIV_ASN;
         "%=":    h.code = OP_MOD_ASN;
         "|=":    h.code = OP_OR_ASN;
         "^=":    h.code = OP_XOR_ASN;
         "<=":    h.code = OP_LE;
         ">=":    h.code = OP_GE;
         "!=":    h.code = OP_NE;
         "==":    h.code = OP_EQ;
         "&&":    h.code = OP_LAND;
         "||":    h.code = OP_LOR;
         "->":    h.code = OP_ARROW;
         default: h.hit  = 1'b0;
      endcase
      return h;
   endfunction

   function automatic logic starts2(input logic [7:0] a);
      return (a == "+") || (a == "-") || (a == "<") || (a == ">") || (a == "*") ||
             (a == "/") || (a == "%") || (a == "|") || (a == "^") || (a == "!") ||
             (a == "=") || (a == "&");
   endfunction

   function automatic op_hit_type find1(input logic [7:0] a);
      op_hit_type h;
      h = '{hit: 1'b1, code: OP_ADD};
      case (a)
         "+":     h.code = OP_ADD;
         "-":     h.code = OP_SUB;
         "*":     h.code = OP_MUL;
         "/":     h.code = OP_DIV;
         "%":     h.code = OP_MOD;
         "|":     h.code = OP_OR;
         "&":     h.code = OP_AND;
         "~":     h.code = OP_NOT;
         "^":     h.code = OP_XOR;
         "=":     h.code = OP_ASN;
         "!":     h.code = OP_LNOT;
         "<":     h.code = OP_LT;
         ">":     h.code = OP_GT;
         default: h.hit  = 1'b0;
      endcase
      return h;
   endfunction

   // reported depth saturates to the signed byte range
   function automatic logic signed [7:0] clamp_level(input logic signed [DEPTH_BITS-1:0] d);
      logic signed [LEVEL_CALC_BITS-1:0] w;
      w = LEVEL_CALC_BITS'(d);
      if (w > LEVEL_CALC_BITS'(127)) begin
         return 8'sd127;
      end else if (w < LEVEL_CALC_BITS'(-128)) begin
         return -8'sd128;
      end
      return 8'(w);
   endfunction

   // append one token, tagged with the running depth
   function automatic step_type put(input step_type s, input token_kind_type k,
                                    input logic [7:0] ch, input logic [5:0] op,
                                    input logic last, input logic grp);
      step_type r;
      r = s;
      if (r.cnt != 2'(MAX_RESULTS)) begin
         r.res[r.cnt] = '{kind: k, char_value: ch, operator_code: op,
                          nesting_level: clamp_level(r.st.depth),
                          ident_last: last, group_end: grp};
         r.cnt = r.cnt + 2'd1;
      end
      return r;
   endfunction

   // a byte seen between tokens
   function automatic step_type from_idle(input step_type s, input logic [7:0] b);
      step_type   r;
      op_hit_type h1;
      r = s;
      h1 = find1(b);
      r.st.mode = MODE_IDLE;
      r.st.held_count = 2'd0;
      if (is_space(b)) begin
         r = r;
      end else if (b == ";" || b == "," || b == ".") begin
         r = put(r, KIND_PUNCT, ";", '0, 1'b0, 1'b1);
      end else if (b == "(" || b == "{" || b == "[") begin
         if (r.st.depth != DEPTH_MAX) begin
            r.st.depth = r.st.depth + DEPTH_BITS'(1);
         end
         r = put(r, KIND_PUNCT, b, '0, 1'b0, 1'b0);
      end else if (b == ")" || b == "}" || b == "]") begin
         r = put(r, KIND_PUNCT, b, '0, 1'b0, 1'b0);
         if (r.st.depth != DEPTH_MIN) begin
            r.st.depth = r.st.depth - DEPTH_BITS'(1);
         end
      end else if (is_alnum(b)) begin
         r.st.mode = MODE_IDENT;
         r.st.held0 = b;
      end else if (starts2(b)) begin
         r.st.mode = MODE_OPER;
         r.st.held0 = b;
         r.st.held_count = 2'd1;
      end else if (h1.hit) begin
         r = put(r, KIND_OPER, 8'h00, h1.code, 1'b0, 1'b0);
      end
      return r;
   endfunction

   // full effect of one input word: next state and up to three tokens
   function automatic step_type lex_step(input lex_state_type cur, input logic [7:0] b,
                                         input logic fin);
      step_type   s;
      op_hit_type h3;
      op_hit_type h2;
      op_hit_type hp;
      op_hit_type h1;
      logic [7:0] c0;
      logic [7:0] c1;
      s.st  = cur;
      s.res = '0;
      s.cnt = 2'd0;
      c0 = cur.held0;
      c1 = cur.held1;
      h3 = find3(c0, c1, b);
      h2 = find2(c0, b);
      hp = find2(c0, c1);
      h1 = find1(c0);
      case (cur.mode)
         MODE_IDENT: begin
            if (is_alnum(b) || b == "_") begin
               s = put(s, KIND_IDENT, c0, '0, 1'b0, 1'b0);
               s.st.held0 = b;
            end else begin
               s = put(s, KIND_IDENT, c0, '0, 1'b1, 1'b0);
               s = from_idle(s, b);
            end
         end
         MODE_OPER: begin
            if (cur.held_count == 2'd2) begin
               if (h3.hit) begin
                  s = put(s, KIND_OPER, 8'h00, h3.code, 1'b0, 1'b0);
                  s.st.mode = MODE_IDLE;
                  s.st.held_count = 2'd0;
               end else begin
                  s = put(s, KIND_OPER, 8'h00, hp.code, 1'b0, 1'b0);
                  s = from_idle(s, b);
               end
            end else if (c0 == "/" && b == "/") begin
               s.st.mode = MODE_LINE;
               s.st.held_count = 2'd0;
            end else if (c0 == "/" && b == "*") begin
               s.st.mode = MODE_BLOCK;
               s.st.held_count = 2'd0;
            end else if (prefix3(c0, b)) begin
               s.st.held1 = b;
               s.st.held_count = 2'd2;
            end else if (h2.hit) begin
               s = put(s, KIND_OPER, 8'h00, h2.code, 1'b0, 1'b0);
               s.st.mode = MODE_IDLE;
               s.st.held_count = 2'd0;
            end else begin
               s = put(s, KIND_OPER, 8'h00, h1.code, 1'b0, 1'b0);
               s = from_idle(s, b);
            end
         end
         MODE_LINE: begin
            if (b == "\n") begin
               s.st.mode = MODE_IDLE;
            end
         end
         MODE_BLOCK: begin
            if (b == "*") begin
               s.st.mode = MODE_STAR;
            end
         end
         MODE_STAR: begin
            if (b == "/") begin
               s.st.mode = MODE_IDLE;
            end else if (b != "*") begin
               s.st.mode = MODE_BLOCK;
            end
         end
         default: begin
            s = from_idle(s, b);
         end
      endcase

      // flush whatever is pending, then the end marker
      if (fin) begin
         if (s.st.mode == MODE_IDENT) begin
            s = put(s, KIND_IDENT, s.st.held0, '0, 1'b1, 1'b0);
         end else if (s.st.mode == MODE_OPER) begin
            if (s.st.held_count == 2'd2) begin
               hp = find2(s.st.held0, s.st.held1);
               s = put(s, KIND_OPER, 8'h00, hp.code, 1'b0, 1'b0);
            end else begin
               h1 = find1(s.st.held0);
               s = put(s, KIND_OPER, 8'h00, h1.code, 1'b0, 1'b0);
            end
         end
         s = put(s, KIND_END, 8'h00, '0, 1'b0, 1'b0);
         s.st = LEX_RESET;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== design/clt_channels.sv =====
// ----------------------------------------------------------------------------
// clt_channels
// valid/ready channels of the lexer: source text in, tokens out
// ----------------------------------------------------------------------------
`default_nettype none

interface clt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface clt_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        token_kind;
   logic [7:0]        char_value;
   logic [5:0]        operator_code;
   logic signed [7:0] nesting_level;
   logic              ident_last;
   logic              group_end;

   modport source (output valid, output token_kind, output char_value,
                   output operator_code, output nesting_level, output ident_last,
                   output group_end, input ready);
   modport sink   (input valid, input token_kind, input char_value,
                   input operator_code, input nesting_level, input ident_last,
                   input group_end, output ready);
endinterface

`default_nettype wire

// ===== design/c_like_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// c_like_token_lexer_unit: streaming c-like lexer, one text byte per word
// queue: a word's tokens are registered in a six-entry queue, after any waiting
// throughput: one word per cycle while each word gives at most one token and
//   sink keeps up; otherwise set by the token port, one token per cycle
// reset: synchronous, clears scan state, depth and token queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_like_token_lexer_unit_assert.svh"

module c_like_token_lexer_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   clt_req_if.sink    req_ch,
   clt_rsp_if.source  rsp_ch
);

   // scan state: mode, held lookahead bytes, bracket depth
   clt_pkg::lex_state_type state_ff;
   clt_pkg::lex_state_type state_in;

   // token queue, head in slot zero
   clt_pkg::result_type                   slot_ff [clt_pkg::RSP_SLOTS];
   clt_pkg::result_type                   slot_in [clt_pkg::RSP_SLOTS];
   logic [clt_pkg::COUNT_BITS-1:0]        count_ff;
   logic [clt_pkg::COUNT_BITS-1:0]        count_in;

   clt_pkg::step_type                     step;
   logic                                  accept;
   logic                                  pop;
   logic [clt_pkg::COUNT_BITS-1:0]        keep;
   logic [clt_pkg::COUNT_BITS-1:0]        pushed;

   // one-bit flag widened to the count width
   function automatic logic [clt_pkg::COUNT_BITS-1:0] COUNT_BITS_ONE(input logic f);
      return {{(clt_pkg::COUNT_BITS-1){1'b0}}, f};
   endfunction

   // a word may be taken whenever room for a full set of tokens is left,
   // even while the head token waits on the sink
   assign req_ch.ready = (count_ff <= clt_pkg::COUNT_BITS'(clt_pkg::RSP_SLOTS -
                                                          clt_pkg::MAX_RESULTS));
   assign accept = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = (count_ff != '0);
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   // lexing of the incoming byte, all within this cycle
   assign step = clt_pkg::lex_step(state_ff, req_ch.text_byte, req_ch.end_of_text);

   // next scan state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = step.st;
      end
   end

   // queue update: shift on pop, append the new tokens behind what stays
   always_comb begin
      keep   = count_ff - COUNT_BITS_ONE(pop);
      pushed = accept ? clt_pkg::COUNT_BITS'(step.cnt) : '0;
      for (int i = 0; i < clt_pkg::RSP_SLOTS; i++) begin
         if (pop && (i < clt_pkg::RSP_SLOTS - 1)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (accept && (i >= int'(keep)) && (i < int'(keep) + int'(step.cnt))) begin
            slot_in[i] = step.res[2'(i - int'(keep))];
         end
      end
      count_in = keep + pushed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clt_pkg::LEX_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // token payload needs no reset
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // head of the queue drives the token port
   assign rsp_ch.token_kind    = slot_ff[0].kind;
   assign rsp_ch.char_value    = slot_ff[0].char_value;
   assign rsp_ch.operator_code = slot_ff[0].operator_code;
   assign rsp_ch.nesting_level = slot_ff[0].nesting_level;
   assign rsp_ch.ident_last    = slot_ff[0].ident_last;
   assign rsp_ch.group_end     = slot_ff[0].group_end;

   // queue never holds more than its slots
   `CLT_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= clt_pkg::COUNT_BITS'(clt_pkg::RSP_SLOTS), "token queue overflow")

   // a second held operator byte only exists inside an operator
   `CLT_ASSERT_ALWAYS(a_held_pair_mode, clock, reset,
      (state_ff.held_count != 2'd2) || (state_ff.mode == clt_pkg::MODE_OPER),
      "held operator pair outside operator mode")

   // end of text returns scanner and depth to their reset values
   `CLT_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_ch.end_of_text,
      (state_ff.mode == clt_pkg::MODE_IDLE) && (state_ff.depth == '0) &&
      (state_ff.held_count == 2'd0), "state not cleared after end of text")

   // end of text always leaves at least the end marker queued
   `CLT_ASSERT_NEXT(a_end_marker_queued, clock, reset, accept && req_ch.end_of_text,
      count_ff != '0, "end marker missing from token queue")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// streams c-like source text through the lexer one byte per word and checks every
// token against a scan-state predictor kept in step with the input side, or typed rows
// ----------------------------------------------------------------------------

module tb;
   import clt_pkg::*;

   // token as seen on the result channel
   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        ch;
      logic [5:0]        op;
      logic signed [7:0] lvl;
      logic              last;
      logic              grp;
   } lex_token_type;

   // one row of the directed text; typed rows carry their tokens inline
   typedef struct packed {
      logic [7:0]    b;
      logic          fin;
      logic [1:0]    typed;
      lex_token_type t0;
      lex_token_type t1;
   } text_row_type;

   // operator spelling, right-aligned in three bytes, with its length
   typedef struct packed {
      logic [23:0] txt;
      logic [1:0]  len;
      op_code_type code;
   } op_entry_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PHASE_BYTES    = 10;
   localparam int DEPTH_TOP      = (1 << (DEPTH_BITS - 1)) - 1;
   localparam int DEPTH_BOT      = -DEPTH_TOP - 1;

   localparam string ALNUM       =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   localparam string IDENT_TAIL  =
      "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   localparam string PUNCT_CHARS = ";,.(){}[]";
   localparam string BODY_CHARS  = "ab */";

   localparam op_entry_type OP_LIST [0:33] = '{
      '{"<<=", 2'd3, OP_SHL_ASN}, '{">>=", 2'd3, OP_SHR_ASN}, '{"<=>", 2'd3, OP_SPACESHIP},
      '{"++", 2'd2, OP_INC},      '{"--", 2'd2, OP_DEC},      '{"<<", 2'd2, OP_SHL},
      '{">>", 2'd2, OP_SHR},      '{"+=", 2'd2, OP_ADD_ASN},  '{"-=", 2'd2, OP_SUB_ASN},
      '{"*=", 2'd2, OP_MUL_ASN},  '{"/=", 2'd2, OP_DIV_ASN},  '{"%=", 2'd2, OP_MOD_ASN},
      '{"|=", 2'd2, OP_OR_ASN},   '{"^=", 2'd2, OP_XOR_ASN},  '{"<=", 2'd2, OP_LE},
      '{">=", 2'd2, OP_GE},       '{"!=", 2'd2, OP_NE},       '{"==", 2'd2, OP_EQ},
      '{"&&", 2'd2, OP_LAND},     '{"||", 2'd2, OP_LOR},      '{"->", 2'd2, OP_ARROW},
      '{"+", 2'd1, OP_ADD},       '{"-", 2'd1, OP_SUB},       '{"*", 2'd1, OP_MUL},
      '{"/", 2'd1, OP_DIV},       '{"%", 2'd1, OP_MOD},       '{"|", 2'd1, OP_OR},
      '{"&", 2'd1, OP_AND},       '{"~", 2'd1, OP_NOT},       '{"^", 2'd1, OP_XOR},
      '{"=", 2'd1, OP_ASN},       '{"!", 2'd1, OP_LNOT},      '{"<", 2'd1, OP_LT},
      '{">", 2'd1, OP_GT}
   };

   localparam lex_token_type NO_TOKEN    = '0;
   localparam lex_token_type END_AT_ZERO = '{KIND_END, 8'h00, 6'd0, 8'sd0, 1'b0, 1'b0};

   // directed text: extremes, each operator length, leading underscore,
   // block comment that must not close on its own opener, flushes at end
   localparam text_row_type DIRECTED_ROWS [0:24] = '{
      '{8'h00, 1'b1, 2'd1, END_AT_ZERO, NO_TOKEN},
      '{8'hFF, 1'b1, 2'd1, END_AT_ZERO, NO_TOKEN},
      '{".",   1'b1, 2'd2, '{KIND_PUNCT, ";", 6'd0, 8'sd0, 1'b0, 1'b1}, END_AT_ZERO},
      '{"~",   1'b1, 2'd2, '{KIND_OPER, 8'h00, OP_NOT, 8'sd0, 1'b0, 1'b0}, END_AT_ZERO},
      '{"(",   1'b1, 2'd2, '{KIND_PUNCT, "(", 6'd0, 8'sd1, 1'b0, 1'b0},
                           '{KIND_END, 8'h00, 6'd0, 8'sd1, 1'b0, 1'b0}},
      '{")",   1'b1, 2'd2, '{KIND_PUNCT, ")", 6'd0, 8'sd0, 1'b0, 1'b0},
                           '{KIND_END, 8'h00, 6'd0, -8'sd1, 1'b0, 1'b0}},
      '{"<", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"<", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"=", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"<", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"=", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{">", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"_", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"a", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"_", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"9", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"/", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"*", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"/", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"*", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"/", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{">", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{">", 1'b1, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"a", 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
      '{"(", 1'b1, 2'd0, NO_TOKEN, NO_TOKEN}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   clt_req_if req_ch ();
   clt_rsp_if rsp_ch ();

   c_like_token_lexer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // predictor scan state
   mode_type    lex_mode;
   logic [7:0]  lex_hold0;
   logic [7:0]  lex_hold1;
   int          lex_hold_n;
   int          lex_depth;
   int          step_tokens;

   lex_token_type expected_tokens [$];
   logic [7:0]    text_buf [$];

   int idle_pct;
   int stall_pct;
   int hold_left;
   bit long_hold_req;
   int mismatches;
   int quiet_cycles;

   // ---------------------------------------------------------------------
   // queue helpers
   // ---------------------------------------------------------------------
   task automatic queue_token(input lex_token_type t);
      expected_tokens = {expected_tokens, t};
   endtask

   task automatic append_byte(input logic [7:0] c);
      text_buf = {text_buf, c};
   endtask

   // ---------------------------------------------------------------------
   // operator lookups, all derived from the spelling list
   // ---------------------------------------------------------------------
   function automatic bit op_known(input logic [1:0] n, input logic [23:0] t);
      for (int i = 0; i < 34; i++) begin
         if (OP_LIST[i].len == n && OP_LIST[i].txt == t) return 1'b1;
      end
      return 1'b0;
   endfunction

   // code of the spelling, zero where it is no operator
   function automatic logic [5:0] op_value(input logic [1:0] n, input logic [23:0] t);
      for (int i = 0; i < 34; i++) begin
         if (OP_LIST[i].len == n && OP_LIST[i].txt == t) return OP_LIST[i].code;
      end
      return '0;
   endfunction

   // does some operator of length n begin with these leading bytes
   function automatic bit op_opens(input logic [1:0] n, input logic [15:0] head);
      for (int i = 0; i < 34; i++) begin
         if (OP_LIST[i].len == n) begin
            if (n == 2'd3 && OP_LIST[i].txt[23:8] == head) return 1'b1;
            if (n == 2'd2 && OP_LIST[i].txt[15:8] == head[7:0]) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit is_word_start(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   task automatic lexer_reset();
      lex_mode   = MODE_IDLE;
      lex_hold0  = 8'h00;
      lex_hold1  = 8'h00;
      lex_hold_n = 0;
      lex_depth  = 0;
   endtask

   // queue one token tagged with the running depth, three per word at most
   task automatic add_token(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [5:0] op, input logic last, input logic grp);
      lex_token_type t;
      int            lv;
      if (step_tokens >= MAX_RESULTS) return;
      lv = lex_depth;
      if (lv > 127) lv = 127;
      if (lv < -128) lv = -128;
      t = '{kind, ch, op, 8'(lv), last, grp};
      queue_token(t);
      step_tokens++;
   endtask

   // byte met between tokens
   task automatic scan_fresh(input logic [7:0] b);
      lex_mode   = MODE_IDLE;
      lex_hold_n = 0;
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
         return;
      end else if (b == ";" || b == "," || b == ".") begin
         add_token(KIND_PUNCT, ";", '0, 1'b0, 1'b1);
      end else if (b == "(" || b == "{" || b == "[") begin
         if (lex_depth < DEPTH_TOP) lex_depth++;
         add_token(KIND_PUNCT, b, '0, 1'b0, 1'b0);
      end else if (b == ")" || b == "}" || b == "]") begin
         add_token(KIND_PUNCT, b, '0, 1'b0, 1'b0);
         if (lex_depth > DEPTH_BOT) lex_depth--;
      end else if (is_word_start(b)) begin
         lex_mode  = MODE_IDENT;
         lex_hold0 = b;
      end else if (op_opens(2'd2, {8'h00, b})) begin
         lex_mode   = MODE_OPER;
         lex_hold0  = b;
         lex_hold_n = 1;
      end else if (op_known(2'd1, {16'h0000, b})) begin
         add_token(KIND_OPER, 8'h00, op_value(2'd1, {16'h0000, b}), 1'b0, 1'b0);
      end
   endtask

   // tokens caused by one accepted word
   task automatic lex_predict(input logic [7:0] b, input logic fin);
      step_tokens = 0;
      case (lex_mode)
         MODE_IDENT: begin
            if (is_word_start(b) || b == "_") begin
               add_token(KIND_IDENT, lex_hold0, '0, 1'b0, 1'b0);
               lex_hold0 = b;
            end else begin
               add_token(KIND_IDENT, lex_hold0, '0, 1'b1, 1'b0);
               scan_fresh(b);
            end
         end
         MODE_OPER: begin
            if (lex_hold_n == 2) begin
               if (op_known(2'd3, {lex_hold0, lex_hold1, b})) begin
                  add_token(KIND_OPER, 8'h00, op_value(2'd3, {lex_hold0, lex_hold1, b}),
                            1'b0, 1'b0);
                  lex_mode   = MODE_IDLE;
                  lex_hold_n = 0;
               end else begin
                  add_token(KIND_OPER, 8'h00, op_value(2'd2, {8'h00, lex_hold0, lex_hold1}),
                            1'b0, 1'b0);
                  scan_fresh(b);
               end
            end else if (lex_hold0 == "/" && b == "/") begin
               lex_mode   = MODE_LINE;
               lex_hold_n = 0;
            end else if (lex_hold0 == "/" && b == "*") begin
               lex_mode   = MODE_BLOCK;
               lex_hold_n = 0;
            end else if (op_opens(2'd3, {lex_hold0, b})) begin
               lex_hold1  = b;
               lex_hold_n = 2;
            end else if (op_known(2'd2, {8'h00, lex_hold0, b})) begin
               add_token(KIND_OPER, 8'h00, op_value(2'd2, {8'h00, lex_hold0, b}), 1'b0, 1'b0);
               lex_mode   = MODE_IDLE;
               lex_hold_n = 0;
            end else begin
               add_token(KIND_OPER, 8'h00, op_value(2'd1, {16'h0000, lex_hold0}), 1'b0, 1'b0);
               scan_fresh(b);
            end
         end
         MODE_LINE: begin
            if (b == "\n") lex_mode = MODE_IDLE;
         end
         MODE_BLOCK: begin
            if (b == "*") lex_mode = MODE_STAR;
         end
         MODE_STAR: begin
            if (b == "/") lex_mode = MODE_IDLE;
            else if (b != "*") lex_mode = MODE_BLOCK;
         end
         default: begin
            scan_fresh(b);
         end
      endcase

      // end of text: flush held bytes, then the marker, then back to reset
      if (fin) begin
         if (lex_mode == MODE_IDENT) begin
            add_token(KIND_IDENT, lex_hold0, '0, 1'b1, 1'b0);
         end else if (lex_mode == MODE_OPER) begin
            if (lex_hold_n == 2)
               add_token(KIND_OPER, 8'h00, op_value(2'd2, {8'h00, lex_hold0, lex_hold1}),
                         1'b0, 1'b0);
            else
               add_token(KIND_OPER, 8'h00, op_value(2'd1, {16'h0000, lex_hold0}), 1'b0, 1'b0);
         end
         add_token(KIND_END, 8'h00, '0, 1'b0, 1'b0);
         lexer_reset();
      end
   endtask

   // ---------------------------------------------------------------------
   // source side
   // ---------------------------------------------------------------------

   // offer one word, with a random gap first; returns at the accepting edge
   // valid is left high so a back-to-back word needs no second assignment
   task automatic send_word(input logic [7:0] b, input logic fin);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_byte   <= b;
      req_ch.end_of_text <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // sender holds off until every outstanding token has been seen
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_word(text_buf[i], i == text_buf.size() - 1);
         lex_predict(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   // long bracket run, enough to pin the depth at its limit
   task automatic send_bracket_run(input logic [7:0] b, input int count);
      text_buf.delete();
      repeat (count) append_byte(b);
      send_text();
   endtask

   // random text built from well-formed fragments, with some noise and
   // now and then a comment left open at the end
   task automatic build_text();
      int pick;
      int len;
      int op_i;
      text_buf.delete();
      repeat ($urandom_range(1, 10)) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            append_byte(ALNUM[$urandom_range(0, 61)]);
            len = $urandom_range(0, 5);
            repeat (len) append_byte(IDENT_TAIL[$urandom_range(0, 62)]);
         end else if (pick < 50) begin
            op_i = $urandom_range(0, 33);
            for (int k = OP_LIST[op_i].len - 1; k >= 0; k--)
               append_byte(OP_LIST[op_i].txt[8*k +: 8]);
         end else if (pick < 63) begin
            append_byte(PUNCT_CHARS[$urandom_range(0, 8)]);
         end else if (pick < 73) begin
            len = $urandom_range(0, 5);
            append_byte(len == 0 ? 8'h20 : 8'(8 + len));
         end else if (pick < 79) begin
            append_byte("/");
            append_byte("/");
            repeat ($urandom_range(0, 4)) append_byte(BODY_CHARS[$urandom_range(0, 4)]);
            append_byte("\n");
         end else if (pick < 87) begin
            append_byte("/");
            append_byte("*");
            repeat ($urandom_range(0, 4)) append_byte(BODY_CHARS[$urandom_range(0, 4)]);
            append_byte("*");
            append_byte("/");
         end else begin
            append_byte(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         append_byte("/");
         append_byte($urandom_range(0, 1) ? "*" : "/");
         repeat ($urandom_range(0, 2)) append_byte(BODY_CHARS[$urandom_range(0, 4)]);
      end
   endtask

   // ---------------------------------------------------------------------
   // token side: ready with random stalls, and a long hold on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // compare each accepted token with the oldest one predicted
   always @(posedge clock) begin
      lex_token_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d char %0h", rsp_ch.token_kind, rsp_ch.char_value);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_ch.token_kind !== want.kind) begin
               $error("token_kind: expected %0d, got %0d", want.kind, rsp_ch.token_kind);
               mismatches++;
            end
            if (rsp_ch.char_value !== want.ch) begin
               $error("char_value: expected %0h, got %0h", want.ch, rsp_ch.char_value);
               mismatches++;
            end
            if (rsp_ch.operator_code !== want.op) begin
               $error("operator_code: expected %0d, got %0d", want.op, rsp_ch.operator_code);
               mismatches++;
            end
            if (rsp_ch.nesting_level !== want.lvl) begin
               $error("nesting_level: expected %0d, got %0d", want.lvl, rsp_ch.nesting_level);
               mismatches++;
            end
            if (rsp_ch.ident_last !== want.last) begin
               $error("ident_last: expected %0b, got %0b", want.last, rsp_ch.ident_last);
               mismatches++;
            end
            if (rsp_ch.group_end !== want.grp) begin
               $error("group_end: expected %0b, got %0b", want.grp, rsp_ch.group_end);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.text_byte   <= 8'h00;
      req_ch.end_of_text <= 1'b0;
      idle_pct      = 0;
      stall_pct     = 0;
      hold_left     = 0;
      long_hold_req = 1'b0;
      mismatches    = 0;
      quiet_cycles  = 0;
      lexer_reset();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows; typed ones all start and end in the reset state
      for (int i = 0; i < 25; i++) begin
         send_word(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].fin);
         if (DIRECTED_ROWS[i].typed == 2'd0) begin
            lex_predict(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].fin);
         end else begin
            queue_token(DIRECTED_ROWS[i].t0);
            if (DIRECTED_ROWS[i].typed == 2'd2) queue_token(DIRECTED_ROWS[i].t1);
            lexer_reset();
         end
      end
      wait_drained();

      // random phases: free running, sender gaps, token stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         int sent;
         sent = 0;
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         // token side held off while openers keep coming: the queue fills
         // and the input must back-pressure; depth pins at its top
         if (phase == 0) begin
            long_hold_req = 1'b1;
            send_bracket_run("(", DEPTH_TOP + 3);
         end
         // closers from zero drive the depth down to its floor and hold it there
         if (phase == 3) send_bracket_run(")", -DEPTH_BOT + 2);
         while (sent < PHASE_BYTES) begin
            build_text();
            send_text();
            sent += text_buf.size();
         end
         wait_drained();
      end

      req_ch.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== c_like_token_lexer_unit.f =====
+incdir+design
design/clt_pkg.sv
design/clt_channels.sv
design/c_like_token_lexer_unit.sv
tb/sv/tb.sv
